[rtl/fsn_pkg.sv]
// fsn_pkg: types and fixed constants for the fractal simplex noise block
// no dependencies; used by fsn_front, fsn_engine and the top level
package fsn_pkg;

  localparam int COORD_BITS   = 12;
  localparam int PERM_ENTRIES = 256;
  localparam int PERM_W       = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE = 1'd1;

  localparam logic [3:0]  OCTAVE_RESET  = 4'd3;
  localparam logic [15:0] INV_SCALE_RST = 16'd1638;

  localparam logic [0:0] OP_RESEED = 1'b0;
  localparam logic [0:0] OP_SAMPLE = 1'b1;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [14:0] SKEW_F2   = 15'd23988;
  localparam logic [13:0] UNSKEW_G2 = 14'd13849;

  localparam logic signed [15:0] TH_WATER = -16'sd9830;
  localparam logic signed [15:0] TH_DIRT  = -16'sd1638;
  localparam logic signed [15:0] TH_GRASS = 16'sd14746;

  localparam logic [1:0] TERRAIN_WATER = 2'd0;
  localparam logic [1:0] TERRAIN_DIRT  = 2'd1;
  localparam logic [1:0] TERRAIN_GRASS = 2'd2;
  localparam logic [1:0] TERRAIN_STONE = 2'd3;

  typedef enum logic {
    CMD_RESEED = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic [0:0]            opcode;
    logic [31:0]           seed_value;
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [0:0]         is_sample;
    logic signed [15:0] noise_value;
    logic [1:0]         terrain_class;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [31:0]           seed;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } cmd_t;

  localparam logic [7:0] BASE_TABLE [PERM_ENTRIES] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
    8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
    8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
    8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
    8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
    8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
    8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
    8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
    8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
    8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
    8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
    8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
    8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
    8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

endpackage

[rtl/fsn_fifo.sv]
// fsn_fifo: two-entry queue for one transaction type
// depends on nothing but the type it is given
module fsn_fifo #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  T           slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

[rtl/fsn_front.sv]
// fsn_front: input side; decodes each transaction into a command and queues it
// depends on fsn_pkg and fsn_fifo
module fsn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  fsn_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output fsn_pkg::cmd_t     cmd
);

  fsn_pkg::cmd_t dec;
  logic          q_empty;

  always_comb begin
    dec.kind = (in_item.opcode == fsn_pkg::OP_RESEED) ? fsn_pkg::CMD_RESEED
                                                      : fsn_pkg::CMD_SAMPLE;
    dec.seed = in_item.seed_value;
    dec.x    = in_item.x_coord;
    dec.y    = in_item.y_coord;
  end

  fsn_fifo #(.T(fsn_pkg::cmd_t)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (dec),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd),
    .empty (q_empty)
  );

  assign cmd_valid = !q_empty;

endmodule

[rtl/fsn_div.sv]
// fsn_div: restoring divider, one quotient bit per cycle
// no package dependency; shared by the shuffle pick and the final normalise
module fsn_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 9,
  parameter int CNT_W = $clog2(NUM_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [CNT_W-1:0] steps,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic             take;
  logic [DEN_W:0]   rem_sub;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign take    = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= num;
        den_r  <= den;
        quo_r  <= '0;
        rem_r  <= '0;
        cnt_r  <= steps;
      end else if (busy_r) begin
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        quo_r <= {quo_r[NUM_W-2:0], take};
        rem_r <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

[rtl/fsn_engine.sv]
// fsn_engine: back end; permutation store, shuffle sequencer and octave datapath
// depends on fsn_pkg and fsn_div
module fsn_engine #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         octave_count,
  input  logic [15:0]        inverse_scale,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  fsn_pkg::cmd_t      cmd,
  output logic               res_push,
  output fsn_pkg::out_item_t res,
  input  logic               res_full
);

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int BX_W  = fsn_pkg::COORD_BITS + 16;
  localparam int XO_W  = BX_W + MAX_OCTAVES - 1;
  localparam int SUM_W = XO_W + 1;
  localparam int I_W   = SUM_W - 16;
  localparam int ACC_W = 45 + MAX_OCTAVES;
  localparam int NUM_W = ACC_W - 17;
  localparam int DEN_W = (MAX_OCTAVES > 9) ? MAX_OCTAVES : 9;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int PW    = fsn_pkg::PERM_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FILL, ST_LCG, ST_DIVS, ST_DIVW, ST_RDP, ST_WRK, ST_WRP,
    ST_SCALE, ST_SKEW, ST_CELL, ST_UNSK, ST_RD1, ST_RD2, ST_GRAD, ST_R2,
    ST_R4, ST_DOT, ST_ACC, ST_NORM, ST_NDIV, ST_OUT
  } state_t;

  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [7:0] a;
    a = v;
    if (a >= 8'd192) a = a - 8'd192;
    if (a >= 8'd96)  a = a - 8'd96;
    if (a >= 8'd48)  a = a - 8'd48;
    if (a >= 8'd24)  a = a - 8'd24;
    if (a >= 8'd12)  a = a - 8'd12;
    return a[3:0];
  endfunction

  function automatic logic signed [20:0] grad_dot(input logic [3:0] g,
                                                  input logic signed [19:0] dx,
                                                  input logic signed [19:0] dy);
    logic signed [20:0] ex;
    logic signed [20:0] ey;
    logic signed [20:0] d;
    ex = 21'(dx);
    ey = 21'(dy);
    case (g)
      4'd0:    d = ex + ey;
      4'd1:    d = ey - ex;
      4'd2:    d = ex - ey;
      4'd3:    d = -ex - ey;
      4'd4:    d = ex;
      4'd5:    d = -ex;
      4'd6:    d = ex;
      4'd7:    d = -ex;
      4'd8:    d = ey;
      4'd9:    d = -ey;
      4'd10:   d = ey;
      4'd11:   d = -ey;
      default: d = '0;
    endcase
    return d;
  endfunction

  logic [7:0] perm_mem [fsn_pkg::PERM_ENTRIES];
  logic [7:0] perm_rd_r;
  logic       mem_we;
  logic [PW-1:0] mem_wa;
  logic [PW-1:0] mem_ra;
  logic [7:0] mem_wd;

  state_t             state_r;
  fsn_pkg::cmd_t      cmd_r;
  logic               ready_r;
  logic [PW-1:0]      fill_r;
  logic [PW-1:0]      k_r;
  logic [31:0]        rng_r;
  logic [7:0]         vk_r;
  logic [PW-1:0]      pick_r;
  logic [OCT_W-1:0]   oct_r;
  logic [OCT_W-1:0]   o_r;
  logic [BX_W-1:0]    bx_r;
  logic [BX_W-1:0]    by_r;
  logic [XO_W-1:0]    xo_r;
  logic [XO_W-1:0]    yo_r;
  logic [XO_W-1:0]    s_r;
  logic [I_W-1:0]     i_r;
  logic [I_W-1:0]     j_r;
  logic signed [19:0] dx0_r;
  logic signed [19:0] dy0_r;
  logic               i1_r;
  logic [1:0]         c_r;
  logic signed [20:0] dot_r;
  logic signed [25:0] r_r;
  logic [14:0]        r2_r;
  logic [12:0]        r4_r;
  logic signed [36:0] csum_r;
  logic signed [ACC_W-1:0] acc_r;
  logic               neg_r;
  fsn_pkg::out_item_t res_r;

  logic [OCT_W-1:0]   oct_clamp;
  logic [XO_W-1:0]    xo_nxt;
  logic [XO_W-1:0]    yo_nxt;
  logic [SUM_W+14:0]  skew_prod;
  logic [SUM_W-1:0]   cell_x;
  logic [SUM_W-1:0]   cell_y;
  logic [I_W+13:0]    t_prod;
  logic [23:0]        dx0_m;
  logic [23:0]        dy0_m;
  logic signed [19:0] dxc;
  logic signed [19:0] dyc;
  logic [PW-1:0]      ac;
  logic [PW-1:0]      bc;
  logic signed [39:0] sqx;
  logic signed [39:0] sqy;
  logic signed [25:0] r_nxt;
  logic [33:0]        r2_prod;
  logic [29:0]        r4_prod;
  logic signed [34:0] contrib;
  logic signed [43:0] scaled;
  logic [OCT_W-1:0]   wsh;
  logic signed [ACC_W-1:0] acc_add;
  logic [ACC_W-1:0]   mag;
  logic [DEN_W-1:0]   den_oct;
  logic [ACC_W-1:0]   norm_sum;
  logic [NUM_W-1:0]   norm_num;
  logic [NUM_W-1:0]   pick_num;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [CNT_W-1:0]   div_steps;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;
  logic [DEN_W-1:0]   div_rem;
  logic signed [15:0] noise_nxt;
  logic [1:0]         class_nxt;

  // octave count clamp
  always_comb begin
    oct_clamp = OCT_W'(octave_count);
    if (octave_count == 4'd0) begin
      oct_clamp = OCT_W'(1);
    end else if (OCT_W'(octave_count) > OCT_W'(MAX_OCTAVES)) begin
      oct_clamp = OCT_W'(MAX_OCTAVES);
    end
  end

  // skew and unskew
  assign xo_nxt    = XO_W'(bx_r) << o_r;
  assign yo_nxt    = XO_W'(by_r) << o_r;
  assign skew_prod = (SUM_W + 15)'({1'b0, xo_r} + {1'b0, yo_r}) *
                     (SUM_W + 15)'(fsn_pkg::SKEW_F2);
  assign cell_x    = {1'b0, xo_r} + {1'b0, s_r};
  assign cell_y    = {1'b0, yo_r} + {1'b0, s_r};
  assign t_prod    = (I_W + 14)'({1'b0, i_r} + {1'b0, j_r}) *
                     (I_W + 14)'(fsn_pkg::UNSKEW_G2);
  assign dx0_m     = xo_r[23:0] + t_prod[23:0] - {i_r[7:0], 16'd0};
  assign dy0_m     = yo_r[23:0] + t_prod[23:0] - {j_r[7:0], 16'd0};

  // corner offsets
  always_comb begin
    case (c_r)
      2'd0: begin
        dxc = dx0_r;
        dyc = dy0_r;
        ac  = i_r[PW-1:0];
        bc  = j_r[PW-1:0];
      end
      2'd1: begin
        dxc = dx0_r - (i1_r ? 20'sd65536 : 20'sd0) + 20'sd13849;
        dyc = dy0_r - (i1_r ? 20'sd0 : 20'sd65536) + 20'sd13849;
        ac  = i_r[PW-1:0] + PW'(i1_r);
        bc  = j_r[PW-1:0] + PW'(!i1_r);
      end
      default: begin
        dxc = dx0_r - 20'sd65536 + 20'sd27698;
        dyc = dy0_r - 20'sd65536 + 20'sd27698;
        ac  = i_r[PW-1:0] + PW'(1);
        bc  = j_r[PW-1:0] + PW'(1);
      end
    endcase
  end

  assign sqx     = dxc * dxc;
  assign sqy     = dyc * dyc;
  assign r_nxt   = 26'sd32768 - $signed({2'b0, sqx[39:16]}) - $signed({2'b0, sqy[39:16]});
  assign r2_prod = r_r[25] ? 34'd0 : ({17'd0, r_r[16:0]} * {17'd0, r_r[16:0]});
  assign r4_prod = {15'd0, r2_r} * {15'd0, r2_r};
  assign contrib = $signed({1'b0, r4_r}) * dot_r;

  // octave weighting
  assign scaled  = 44'(csum_r) * 44'sd70;
  assign wsh     = oct_r - OCT_W'(1) - o_r;
  assign acc_add = ACC_W'(scaled) <<< wsh;

  // normalise
  assign mag      = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign den_oct  = ~({DEN_W{1'b1}} << oct_r);
  assign norm_sum = mag + (ACC_W'(den_oct) << 16);
  assign norm_num = norm_sum[ACC_W-1:17];
  assign pick_num = {rng_r[31:16], (NUM_W-16)'(0)};

  assign div_start = (state_r == ST_DIVS) || (state_r == ST_NORM);
  assign div_num   = (state_r == ST_NORM) ? norm_num : pick_num;
  assign div_den   = (state_r == ST_NORM) ? den_oct : DEN_W'({1'b0, k_r} + 9'd1);
  assign div_steps = (state_r == ST_NORM) ? CNT_W'(NUM_W) : CNT_W'(16);

  fsn_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    if (neg_r) begin
      noise_nxt = (div_quo > NUM_W'(32768)) ? -16'sd32768
                                            : $signed(16'd0 - div_quo[15:0]);
    end else begin
      noise_nxt = (div_quo > NUM_W'(32767)) ? 16'sd32767 : $signed(div_quo[15:0]);
    end
    if (noise_nxt < fsn_pkg::TH_WATER) begin
      class_nxt = fsn_pkg::TERRAIN_WATER;
    end else if (noise_nxt < fsn_pkg::TH_DIRT) begin
      class_nxt = fsn_pkg::TERRAIN_DIRT;
    end else if (noise_nxt < fsn_pkg::TH_GRASS) begin
      class_nxt = fsn_pkg::TERRAIN_GRASS;
    end else begin
      class_nxt = fsn_pkg::TERRAIN_STONE;
    end
  end

  // permutation store port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = k_r;
    mem_wd = perm_rd_r;
    mem_ra = k_r;
    case (state_r)
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = fill_r;
        mem_wd = fsn_pkg::BASE_TABLE[fill_r];
      end
      ST_RDP:  mem_ra = pick_r;
      ST_WRK:  mem_we = 1'b1;
      ST_WRP: begin
        mem_we = 1'b1;
        mem_wa = pick_r;
        mem_wd = vk_r;
      end
      ST_RD1:  mem_ra = bc;
      ST_RD2:  mem_ra = ac + perm_rd_r;
      default: mem_ra = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm_mem[mem_wa] <= mem_wd;
    end
    perm_rd_r <= perm_mem[mem_ra];
  end

  assign cmd_pop  = (state_r == ST_IDLE) && cmd_valid;
  assign res_push = (state_r == ST_OUT) && !res_full;
  assign res      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ready_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            if (cmd.kind == fsn_pkg::CMD_RESEED || !ready_r) begin
              rng_r   <= (cmd.kind == fsn_pkg::CMD_RESEED) ? cmd.seed : 32'd0;
              fill_r  <= '0;
              state_r <= ST_FILL;
            end else begin
              state_r <= ST_SCALE;
            end
          end
        end
        ST_FILL: begin
          fill_r <= fill_r + PW'(1);
          if (fill_r == {PW{1'b1}}) begin
            k_r     <= {PW{1'b1}};
            state_r <= ST_LCG;
          end
        end
        ST_LCG: begin
          rng_r   <= rng_r * fsn_pkg::LCG_MUL + fsn_pkg::LCG_ADD;
          state_r <= ST_DIVS;
        end
        ST_DIVS: state_r <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            pick_r  <= div_rem[PW-1:0];
            vk_r    <= perm_rd_r;
            state_r <= ST_RDP;
          end
        end
        ST_RDP: state_r <= ST_WRK;
        ST_WRK: state_r <= ST_WRP;
        ST_WRP: begin
          k_r <= k_r - PW'(1);
          if (k_r == PW'(1)) begin
            ready_r <= 1'b1;
            if (cmd_r.kind == fsn_pkg::CMD_RESEED) begin
              res_r.is_sample     <= 1'b0;
              res_r.noise_value   <= '0;
              res_r.terrain_class <= fsn_pkg::TERRAIN_WATER;
              state_r             <= ST_OUT;
            end else begin
              state_r <= ST_SCALE;
            end
          end else begin
            state_r <= ST_LCG;
          end
        end
        ST_SCALE: begin
          bx_r    <= BX_W'(cmd_r.x) * BX_W'(inverse_scale);
          by_r    <= BX_W'(cmd_r.y) * BX_W'(inverse_scale);
          oct_r   <= oct_clamp;
          o_r     <= '0;
          acc_r   <= '0;
          state_r <= ST_SKEW;
        end
        ST_SKEW: begin
          xo_r    <= xo_nxt;
          yo_r    <= yo_nxt;
          state_r <= ST_CELL;
        end
        ST_CELL: begin
          s_r     <= skew_prod[XO_W+15:16];
          state_r <= ST_UNSK;
        end
        ST_UNSK: begin
          i_r     <= cell_x[SUM_W-1:16];
          j_r     <= cell_y[SUM_W-1:16];
          state_r <= ST_RD1;
          c_r     <= 2'd3;
        end
        ST_RD1: begin
          // first pass here after cell lookup latches the corner origin
          if (c_r == 2'd3) begin
            dx0_r  <= $signed(dx0_m[19:0]);
            dy0_r  <= $signed(dy0_m[19:0]);
            i1_r   <= $signed(dx0_m[19:0]) > $signed(dy0_m[19:0]);
            c_r    <= 2'd0;
            csum_r <= '0;
          end else begin
            state_r <= ST_RD2;
          end
        end
        ST_RD2: state_r <= ST_GRAD;
        ST_GRAD: begin
          r_r     <= r_nxt;
          dot_r   <= grad_dot(mod12(perm_rd_r), dxc, dyc);
          state_r <= ST_R2;
        end
        ST_R2: begin
          r2_r    <= r2_prod[30:16];
          state_r <= ST_R4;
        end
        ST_R4: begin
          r4_r    <= r4_prod[28:16];
          state_r <= ST_DOT;
        end
        ST_DOT: begin
          csum_r <= csum_r + 37'(contrib);
          if (c_r == 2'd2) begin
            state_r <= ST_ACC;
          end else begin
            c_r     <= c_r + 2'd1;
            state_r <= ST_RD1;
          end
        end
        ST_ACC: begin
          acc_r <= acc_r + acc_add;
          if (o_r == oct_r - OCT_W'(1)) begin
            state_r <= ST_NORM;
          end else begin
            o_r     <= o_r + OCT_W'(1);
            state_r <= ST_SKEW;
          end
        end
        ST_NORM: begin
          neg_r   <= acc_r[ACC_W-1];
          state_r <= ST_NDIV;
        end
        ST_NDIV: begin
          if (div_done) begin
            res_r.is_sample     <= 1'b1;
            res_r.noise_value   <= noise_nxt;
            res_r.terrain_class <= class_nxt;
            state_r             <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!res_full) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/fractal_simplex_noise_2d.sv]
// fractal_simplex_noise_2d: top level; configuration registers, command queue,
// engine and result queue. depends on fsn_pkg, fsn_front, fsn_engine, fsn_fifo
//
// Both sides behave as queues: a transaction is taken while full is low and
// results wait in a two-entry queue until popped, so the front keeps taking
// transactions while the engine works. The engine handles one transaction at
// a time. A sample is paced by the per-corner sequence on the single
// permutation store port and the bit-serial normalising divider. A reseed
// copies the 256-entry base table and then runs 255 swap steps, each paced
// by the modulo pick on the divider; the first sample after reset pays for a
// reseed with seed 0 before it is evaluated. Configuration is to be written
// only while idle; the block itself does not enforce this.
module fractal_simplex_noise_2d #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  fsn_pkg::in_item_t                 in_item,
  output logic                              empty,
  input  logic                              pop,
  output fsn_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [fsn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fsn_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [3:0]         octave_count_r;
  logic [15:0]        inverse_scale_r;
  logic               cmd_valid;
  logic               cmd_pop;
  fsn_pkg::cmd_t      cmd;
  logic               res_push;
  logic               res_full;
  fsn_pkg::out_item_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r  <= fsn_pkg::OCTAVE_RESET;
      inverse_scale_r <= fsn_pkg::INV_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fsn_pkg::CFG_OCTAVE_COUNT:  octave_count_r  <= cfg_data[3:0];
        fsn_pkg::CFG_INVERSE_SCALE: inverse_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  fsn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  fsn_engine #(.MAX_OCTAVES(MAX_OCTAVES)) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .octave_count  (octave_count_r),
    .inverse_scale (inverse_scale_r),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .cmd           (cmd),
    .res_push      (res_push),
    .res           (res),
    .res_full      (res_full)
  );

  fsn_fifo #(.T(fsn_pkg::out_item_t)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (out_item),
    .empty (empty)
  );

endmodule
